[hdl/bmhq_pkg.sv]
// bmhq_pkg: shared types and constants for the binary max-heap queue
// used by every module in hdl/; depends on nothing else

package bmhq_pkg;

  // fixed field widths
  localparam int KEY_W       = 32;
  localparam int SLOT_W      = 6;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int OUT_COUNT_W = 7;

  // default heap capacity and command queue depth
  localparam int CAPACITY_DEF = 64;
  localparam int QUEUE_DEPTH  = 2;

  // raw command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHANGE = 2'd2;

  // classified operation
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_CHANGE,
    OP_IGNORE
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_BAD_SLOT = 2'd3
  } status_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM_RD,
    ST_CHG_RD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP
  } state_t;

  // one queued command
  typedef struct packed {
    op_t                      op;
    logic signed [KEY_W-1:0]  key;
    logic        [SLOT_W-1:0] slot;
  } item_t;

endpackage

[hdl/bmhq_front.sv]
// bmhq_front: takes commands off the input port and classifies them
// depends on bmhq_pkg

module bmhq_front (
  input  logic                              start,
  input  logic                              busy,
  input  logic [bmhq_pkg::CMD_W-1:0]        in_command,
  input  logic signed [bmhq_pkg::KEY_W-1:0] in_key_value,
  input  logic [bmhq_pkg::SLOT_W-1:0]       in_slot_index,
  output logic                              push_valid,
  output bmhq_pkg::item_t                   push_item
);

  bmhq_pkg::op_t op;

  always_comb begin
    unique case (in_command)
      bmhq_pkg::CMD_INSERT: op = bmhq_pkg::OP_INSERT;
      bmhq_pkg::CMD_REMOVE: op = bmhq_pkg::OP_REMOVE;
      bmhq_pkg::CMD_CHANGE: op = bmhq_pkg::OP_CHANGE;
      default:              op = bmhq_pkg::OP_IGNORE;
    endcase
  end

  assign push_valid     = start && !busy;
  assign push_item.op   = op;
  assign push_item.key  = in_key_value;
  assign push_item.slot = in_slot_index;

endmodule

[hdl/bmhq_queue.sv]
// bmhq_queue: short command queue between front and back end
// depends on bmhq_pkg

module bmhq_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  bmhq_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output bmhq_pkg::item_t pop_item
);

  localparam int DEPTH = bmhq_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int FW    = $clog2(DEPTH + 1);

  bmhq_pkg::item_t entries_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic            do_push, do_pop;

  assign full      = (fill_r == FW'(DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_item  = entries_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + FW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[hdl/bmhq_back.sv]
// bmhq_back: heap store and sift sequencer, one command at a time
// depends on bmhq_pkg

module bmhq_back #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    pop_valid,
  input  bmhq_pkg::item_t                         pop_item,
  output logic                                    pop,
  output logic                                    out_valid,
  output logic [bmhq_pkg::STATUS_W-1:0]           out_status,
  output logic signed [bmhq_pkg::KEY_W-1:0]       out_removed_key,
  output logic [bmhq_pkg::OUT_COUNT_W-1:0]        out_entry_count
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CW1 = CW + 1;
  localparam int SW  = (CW > bmhq_pkg::SLOT_W) ? CW : bmhq_pkg::SLOT_W;
  localparam int OW  = bmhq_pkg::OUT_COUNT_W;
  localparam int MW  = (CW > OW) ? CW : OW;
  localparam int KW  = bmhq_pkg::KEY_W;

  logic signed [KW-1:0] mem [CAPACITY];

  bmhq_pkg::state_t     state_r, state_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic signed [KW-1:0] moving_r, moving_nxt;
  logic signed [KW-1:0] removed_r, removed_nxt;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic signed [KW-1:0] mem_wdata;
  logic [AW-1:0]        rd0_addr, rd1_addr;
  logic signed [KW-1:0] q0_r, q1_r;

  logic                 resp_valid;
  bmhq_pkg::status_t    resp_status;

  logic [CW-1:0]        count_dec;
  logic [AW-1:0]        last_addr, parent_addr, left_addr, right_addr, pick_addr;
  logic [CW1-1:0]       pos_w, left_w, right_w, count_w;
  logic                 right_in, pick_right, has_child;
  logic signed [KW-1:0] pick_val;
  logic [SW-1:0]        slot_ext, count_ext;
  logic [MW-1:0]        count_out;

  // address arithmetic
  assign count_dec   = count_r - CW'(1);
  assign last_addr   = count_dec[AW-1:0];
  assign parent_addr = (pos_r - AW'(1)) >> 1;
  assign pos_w       = CW1'(pos_r);
  assign count_w     = CW1'(count_r);
  assign left_w      = (pos_w << 1) + CW1'(1);
  assign right_w     = left_w + CW1'(1);
  assign right_in    = (right_w < count_w);
  assign has_child   = (pos_w < (count_w >> 1));
  assign left_addr   = left_w[AW-1:0];
  assign right_addr  = right_in ? right_w[AW-1:0] : left_addr;
  assign pick_right  = right_in && (q0_r < q1_r);
  assign pick_addr   = pick_right ? right_addr : left_addr;
  assign pick_val    = pick_right ? q1_r : q0_r;
  assign slot_ext    = SW'(pop_item.slot);
  assign count_ext   = SW'(count_r);

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    moving_nxt  = moving_r;
    removed_nxt = removed_r;
    pop         = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pos_r;
    mem_wdata   = moving_r;
    rd0_addr    = parent_addr;
    rd1_addr    = right_addr;
    resp_valid  = 1'b0;
    resp_status = bmhq_pkg::STATUS_OK;
    unique case (state_r)
      bmhq_pkg::ST_IDLE: begin
        if (pop_valid) begin
          pop         = 1'b1;
          removed_nxt = '0;
          unique case (pop_item.op)
            bmhq_pkg::OP_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                resp_valid  = 1'b1;
                resp_status = bmhq_pkg::STATUS_FULL;
              end else begin
                moving_nxt = pop_item.key;
                pos_nxt    = count_r[AW-1:0];
                count_nxt  = count_r + CW'(1);
                state_nxt  = bmhq_pkg::ST_UP_RD;
              end
            end
            bmhq_pkg::OP_REMOVE: begin
              if (count_r == '0) begin
                resp_valid  = 1'b1;
                resp_status = bmhq_pkg::STATUS_EMPTY;
              end else begin
                rd0_addr  = '0;
                rd1_addr  = last_addr;
                count_nxt = count_dec;
                state_nxt = bmhq_pkg::ST_REM_RD;
              end
            end
            bmhq_pkg::OP_CHANGE: begin
              if (slot_ext >= count_ext) begin
                resp_valid  = 1'b1;
                resp_status = bmhq_pkg::STATUS_BAD_SLOT;
              end else begin
                rd0_addr   = slot_ext[AW-1:0];
                pos_nxt    = slot_ext[AW-1:0];
                moving_nxt = pop_item.key;
                state_nxt  = bmhq_pkg::ST_CHG_RD;
              end
            end
            default: begin
              resp_valid = 1'b1;
            end
          endcase
        end
      end
      bmhq_pkg::ST_REM_RD: begin
        // root leaves, last entry moves to the root
        removed_nxt = q0_r;
        moving_nxt  = q1_r;
        pos_nxt     = '0;
        state_nxt   = bmhq_pkg::ST_DN_RD;
      end
      bmhq_pkg::ST_CHG_RD: begin
        state_nxt = (q0_r < moving_r) ? bmhq_pkg::ST_UP_RD : bmhq_pkg::ST_DN_RD;
      end
      bmhq_pkg::ST_UP_RD: begin
        if (pos_r == '0) begin
          mem_we     = 1'b1;
          resp_valid = 1'b1;
          state_nxt  = bmhq_pkg::ST_IDLE;
        end else begin
          rd0_addr  = parent_addr;
          state_nxt = bmhq_pkg::ST_UP_CMP;
        end
      end
      bmhq_pkg::ST_UP_CMP: begin
        mem_we = 1'b1;
        if (q0_r < moving_r) begin
          mem_wdata = q0_r;
          pos_nxt   = parent_addr;
          state_nxt = bmhq_pkg::ST_UP_RD;
        end else begin
          resp_valid = 1'b1;
          state_nxt  = bmhq_pkg::ST_IDLE;
        end
      end
      bmhq_pkg::ST_DN_RD: begin
        if (!has_child) begin
          mem_we     = 1'b1;
          resp_valid = 1'b1;
          state_nxt  = bmhq_pkg::ST_IDLE;
        end else begin
          rd0_addr  = left_addr;
          rd1_addr  = right_addr;
          state_nxt = bmhq_pkg::ST_DN_CMP;
        end
      end
      bmhq_pkg::ST_DN_CMP: begin
        mem_we = 1'b1;
        if (moving_r >= pick_val) begin
          resp_valid = 1'b1;
          state_nxt  = bmhq_pkg::ST_IDLE;
        end else begin
          mem_wdata = pick_val;
          pos_nxt   = pick_addr;
          state_nxt = bmhq_pkg::ST_DN_RD;
        end
      end
      default: begin
        state_nxt = bmhq_pkg::ST_IDLE;
      end
    endcase
  end

  assign count_out = MW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bmhq_pkg::ST_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_valid <= resp_valid;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    moving_r  <= moving_nxt;
    removed_r <= removed_nxt;
    if (resp_valid) begin
      out_status      <= resp_status;
      out_removed_key <= removed_nxt;
      out_entry_count <= count_out[OW-1:0];
    end
  end

  // heap store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    q0_r <= mem[rd0_addr];
    q1_r <= mem[rd1_addr];
  end

endmodule

[hdl/binary_max_heap_queue_top.sv]
// binary_max_heap_queue_top: max-heap priority queue of signed 32-bit keys
// depends on bmhq_pkg, bmhq_front, bmhq_queue, bmhq_back
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+--------------------------
//   command  | in_command, in_key_value, in_slot_index        | transfer on start && !busy
//   result   | out_status, out_removed_key, out_entry_count   | transfer on out_valid pulse
//
// flow: a command waits in a two-entry queue, then the sequencer takes it; each
//   heap level walked is a registered read of the heap store, then a compare and
//   write back, and a final write ends the walk; the result is registered and
//   strobes in the cycle after that write. errors and the unused command give
//   their result without walking the heap. a 64-entry heap walks at most 6
//   levels, and the sequencer takes no new command until the walk is done.
// reset: rst_n low clears the entry count, queue and sequencer; heap contents are
//   left as they are and never used before being written
// stalls: busy is high only while the command queue is full; the receiver cannot
//   hold off results, each one is on the ports for exactly one cycle

module binary_max_heap_queue_top #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // command channel
  input  logic                                    start,
  output logic                                    busy,
  input  logic [bmhq_pkg::CMD_W-1:0]              in_command,
  input  logic signed [bmhq_pkg::KEY_W-1:0]       in_key_value,
  input  logic [bmhq_pkg::SLOT_W-1:0]             in_slot_index,
  // result channel
  output logic                                    out_valid,
  output logic [bmhq_pkg::STATUS_W-1:0]           out_status,
  output logic signed [bmhq_pkg::KEY_W-1:0]       out_removed_key,
  output logic [bmhq_pkg::OUT_COUNT_W-1:0]        out_entry_count
);

  // front to queue
  logic            push_valid;
  bmhq_pkg::item_t push_item;

  // queue to back end
  logic            pop;
  logic            pop_valid;
  bmhq_pkg::item_t pop_item;

  // decode the command and offer it to the queue
  bmhq_front u_front (
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_key_value  (in_key_value),
    .in_slot_index (in_slot_index),
    .push_valid    (push_valid),
    .push_item     (push_item)
  );

  // decouples command intake from the sift sequencer; full queue means busy
  bmhq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (busy),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  // heap store, entry count and sift sequencer; drives the result registers
  bmhq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_item        (pop_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_removed_key (out_removed_key),
    .out_entry_count (out_entry_count)
  );

  // an empty-heap result always reports no entries held
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bmhq_pkg::STATUS_EMPTY) |-> (out_entry_count == '0))
    else $error("empty status with nonzero entry count");

  // a full-heap result reports the heap at capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bmhq_pkg::STATUS_FULL) |->
      (out_entry_count == bmhq_pkg::OUT_COUNT_W'(CAPACITY)))
    else $error("full status with entry count below capacity");

  // only error-free removals hand back a key other than zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bmhq_pkg::STATUS_OK) |-> (out_removed_key == '0))
    else $error("error result carries a removed key");

  // the queue can only fill up right after a command transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command transfer");

endmodule
